// ===== hdl/rvc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvc_pkg: shared types and constants for the RV32I subset core
// Memory geometry, request struct, opcode, status and halt codes.
// ----------------------------------------------------------------------------
package rvc_pkg;

    // byte memory, split into four byte lanes
    localparam int unsigned MEM_BYTES = 1048576;
    localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);
    localparam int unsigned LANES     = 4;
    localparam int unsigned ROWS      = MEM_BYTES / LANES;
    localparam int unsigned ROW_AW    = MEM_AW - 2;
    localparam int unsigned LOAD_AW   = 20;

    typedef logic [31:0] word_t;

    // one memory access: be marks the bytes of the word to write (byte 0 at addr)
    typedef struct packed {
        logic [3:0]        be;
        logic [MEM_AW-1:0] addr;
        word_t             wdata;
    } mem_req_t;

    // result status
    localparam logic [2:0] STAT_EXEC    = 3'd0;
    localparam logic [2:0] STAT_GOOD    = 3'd1;
    localparam logic [2:0] STAT_BAD     = 3'd2;
    localparam logic [2:0] STAT_UNKNOWN = 3'd3;
    localparam logic [2:0] STAT_WRITTEN = 3'd4;

    // halt state
    localparam logic [1:0] HALT_RUN     = 2'd0;
    localparam logic [1:0] HALT_GOOD    = 2'd1;
    localparam logic [1:0] HALT_BAD     = 2'd2;
    localparam logic [1:0] HALT_UNKNOWN = 2'd3;

    // opcodes
    localparam logic [6:0] OPC_OPIMM = 7'b0010011;
    localparam logic [6:0] OPC_JALR  = 7'b1100111;
    localparam logic [6:0] OPC_OP    = 7'b0110011;
    localparam logic [6:0] OPC_LUI   = 7'b0110111;
    localparam logic [6:0] OPC_LOAD  = 7'b0000011;
    localparam logic [6:0] OPC_STORE = 7'b0100011;
    localparam word_t      INST_EBREAK = 32'h0010_0073;

    // funct3 values
    localparam logic [2:0] F3_ZERO = 3'd0;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_BU   = 3'd4;

    // register numbers
    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_A0   = 5'd10;

    // byte enables
    localparam logic [3:0] BE_NONE = 4'b0000;
    localparam logic [3:0] BE_BYTE = 4'b0001;
    localparam logic [3:0] BE_WORD = 4'b1111;

endpackage

// ===== hdl/rvc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvc_ram: generic single-port-write, single-port-read synchronous RAM
// Read data registered; no reset.
// ----------------------------------------------------------------------------
module rvc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/rvc_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvc_mem: byte-lane main memory
// Four byte lanes give one unaligned, wrapping word access per cycle.
// ----------------------------------------------------------------------------
module rvc_mem (
    input  logic              aclk,
    input  rvc_pkg::mem_req_t req,
    output rvc_pkg::word_t    rdata
);

    logic [1:0] off;
    logic [1:0] off_reg;
    logic [rvc_pkg::ROW_AW-1:0] row;
    logic [7:0] lane_q [rvc_pkg::LANES];

    assign off = req.addr[1:0];
    assign row = req.addr[rvc_pkg::MEM_AW-1:2];

    for (genvar k = 0; k < rvc_pkg::LANES; k++) begin : g_lane
        logic [1:0]                 byte_idx;
        logic                       carry;
        logic [rvc_pkg::ROW_AW-1:0] lane_row;

        // byte i of the word sits in lane (addr+i)%4; lanes below the offset
        // hold bytes from the next row
        assign byte_idx = 2'(k) - off;
        assign carry    = (2'(k) < off);
        assign lane_row = row + {{(rvc_pkg::ROW_AW-1){1'b0}}, carry};

        rvc_ram #(
            .WIDTH (8),
            .DEPTH (rvc_pkg::ROWS)
        ) u_lane (
            .aclk  (aclk),
            .we    (req.be[byte_idx]),
            .waddr (lane_row),
            .wdata (req.wdata[{byte_idx, 3'b000} +: 8]),
            .raddr (lane_row),
            .rdata (lane_q[k])
        );
    end

    always_ff @(posedge aclk) begin
        off_reg <= off;
    end

    for (genvar i = 0; i < rvc_pkg::LANES; i++) begin : g_rot
        assign rdata[8*i +: 8] = lane_q[2'(off_reg + 2'(i))];
    end

endmodule

// ===== hdl/rvc_regfile.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvc_regfile: 32 x 32 register file
// Two RAM copies for two read ports, valid bits for the zero reset, a0 copy.
// ----------------------------------------------------------------------------
module rvc_regfile (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [4:0]     rs1,
    input  logic [4:0]     rs2,
    output rvc_pkg::word_t q1,
    output rvc_pkg::word_t q2,
    input  logic           we,
    input  logic [4:0]     waddr,
    input  rvc_pkg::word_t wdata,
    output rvc_pkg::word_t a0_next
);

    logic           wr_en;
    logic [31:0]    valid_reg;
    logic [31:0]    valid_next;
    logic           v1_reg;
    logic           v2_reg;
    rvc_pkg::word_t a0_reg;
    rvc_pkg::word_t ram_q1;
    rvc_pkg::word_t ram_q2;

    // x0 is never written and so always reads as an invalid (zero) entry
    assign wr_en = we && (waddr != rvc_pkg::REG_ZERO);

    rvc_ram #(.WIDTH(32), .DEPTH(32)) u_copy1 (
        .aclk (aclk), .we (wr_en), .waddr (waddr), .wdata (wdata),
        .raddr (rs1), .rdata (ram_q1)
    );

    rvc_ram #(.WIDTH(32), .DEPTH(32)) u_copy2 (
        .aclk (aclk), .we (wr_en), .waddr (waddr), .wdata (wdata),
        .raddr (rs2), .rdata (ram_q2)
    );

    always_comb begin
        valid_next = valid_reg;
        if (wr_en) begin
            valid_next[waddr] = 1'b1;
        end
    end

    assign a0_next = (wr_en && (waddr == rvc_pkg::REG_A0)) ? wdata : a0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            a0_reg    <= '0;
        end else begin
            valid_reg <= valid_next;
            v1_reg    <= valid_reg[rs1];
            v2_reg    <= valid_reg[rs2];
            a0_reg    <= a0_next;
        end
    end

    assign q1 = v1_reg ? ram_q1 : '0;
    assign q2 = v2_reg ? ram_q2 : '0;

`ifndef ASSERT_OFF
    a_x0_never_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[0])
        else $error("x0 marked as written");
`endif

endmodule

// ===== hdl/rv32_subset_core_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32_subset_core_top: RV32I subset core (ADDI JALR ADD LUI LW LBU SW SB EBREAK)
// Input items load memory words or step one instruction; one result per item.
// ----------------------------------------------------------------------------
// After reset the core sweeps its byte memory to zero, one 4-byte row per
// cycle; s_tready stays low until the sweep is done. Items then pass
// through a one-entry input register into a sequencer built around two
// synchronous memories (byte-lane main memory, register file), each with
// registered read data. In the sequencer a memory-write item is done in the
// idle state; a step passes through fetch, register read and execute, with
// an extra data read for LW/LBU, while EBREAK, an unknown encoding or a step
// while halted end after fetch and decode. The main-memory port is shared by
// fetch and data access. A new item is taken into the input register while
// earlier ones are still at work. The next item starts only when the output
// register is empty or is being read in that same cycle, so a result left
// waiting holds the sequencer and, once the input register is full, s_tready as
// well. Items are handled in order, so no two accesses to the same entry ever overlap.
// ----------------------------------------------------------------------------
module rv32_subset_core_top (
    input  logic          aclk,
    input  logic          aresetn,
    // input items
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [55:0]   s_tdata,   // [19:0] load_address, [51:20] load_data, pad
    input  logic [0:0]    s_tuser,   // [0] command
    // results
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [95:0]   m_tdata,   // [31:0] program_counter, [63:32] instruction_word,
                                     // [95:64] return_value
    output logic [2:0]    m_tuser    // [2:0] status
);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_LOAD   = 3'd3;
    localparam logic [2:0] ST_CLEAR  = 3'd4;

    // decoded operation classes
    localparam logic [2:0] OP_ADDI = 3'd0;
    localparam logic [2:0] OP_JALR = 3'd1;
    localparam logic [2:0] OP_ADD  = 3'd2;
    localparam logic [2:0] OP_LUI  = 3'd3;
    localparam logic [2:0] OP_LW   = 3'd4;
    localparam logic [2:0] OP_LBU  = 3'd5;
    localparam logic [2:0] OP_SW   = 3'd6;
    localparam logic [2:0] OP_SB   = 3'd7;

    logic [2:0]                 state_reg, state_next;
    logic [rvc_pkg::ROW_AW-1:0] clear_row_reg, clear_row_next;
    rvc_pkg::word_t             pc_reg, pc_next;
    logic [1:0]                 halt_reg, halt_next;
    rvc_pkg::word_t             inst_reg, inst_next;
    logic [2:0]                 op_reg, op_next;

    // input holding register
    logic                        ibuf_valid_reg, ibuf_valid_next;
    logic                        ibuf_cmd_reg;
    logic [rvc_pkg::LOAD_AW-1:0] ibuf_addr_reg;
    rvc_pkg::word_t              ibuf_data_reg;

    // output register
    logic           m_tvalid_reg, m_tvalid_next;
    logic [2:0]     out_status_reg;
    rvc_pkg::word_t out_pc_reg;
    rvc_pkg::word_t out_inst_reg;
    rvc_pkg::word_t out_a0_reg;

    logic out_free;
    logic start;
    logic s_take;

    // result of the finishing item
    logic           done;
    logic [2:0]     res_status;
    rvc_pkg::word_t res_inst;

    // memory and register file hookup
    rvc_pkg::mem_req_t mem_req;
    rvc_pkg::word_t    mem_rdata;
    rvc_pkg::word_t    rf_q1, rf_q2, rf_wdata, rf_a0;
    logic              rf_we;

    // decode and execute terms
    logic [6:0]     dec_opcode;
    logic [2:0]     dec_f3;
    logic [6:0]     dec_f7;
    logic           dec_known;
    logic [2:0]     dec_op;
    rvc_pkg::word_t imm_i, imm_s, sum_i, sum_s, pc_plus4;

    // ---------------- handshakes ----------------
    assign out_free = !m_tvalid_reg || m_tready;
    assign start    = (state_reg == ST_IDLE) && ibuf_valid_reg && out_free;
    assign s_tready = (state_reg != ST_CLEAR) && (!ibuf_valid_reg || start);
    assign s_take   = s_tvalid && s_tready;

    assign ibuf_valid_next = s_take || (ibuf_valid_reg && !start);

    // ---------------- decode ----------------
    assign dec_opcode = mem_rdata[6:0];
    assign dec_f3     = mem_rdata[14:12];
    assign dec_f7     = mem_rdata[31:25];

    always_comb begin
        dec_known = 1'b1;
        dec_op    = OP_ADDI;
        priority if (dec_opcode == rvc_pkg::OPC_OPIMM && dec_f3 == rvc_pkg::F3_ZERO) begin
            dec_op = OP_ADDI;
        end else if (dec_opcode == rvc_pkg::OPC_JALR && dec_f3 == rvc_pkg::F3_ZERO) begin
            dec_op = OP_JALR;
        end else if (dec_opcode == rvc_pkg::OPC_OP && dec_f3 == rvc_pkg::F3_ZERO
                     && dec_f7 == 7'd0) begin
            dec_op = OP_ADD;
        end else if (dec_opcode == rvc_pkg::OPC_LUI) begin
            dec_op = OP_LUI;
        end else if (dec_opcode == rvc_pkg::OPC_LOAD && dec_f3 == rvc_pkg::F3_WORD) begin
            dec_op = OP_LW;
        end else if (dec_opcode == rvc_pkg::OPC_LOAD && dec_f3 == rvc_pkg::F3_BU) begin
            dec_op = OP_LBU;
        end else if (dec_opcode == rvc_pkg::OPC_STORE && dec_f3 == rvc_pkg::F3_WORD) begin
            dec_op = OP_SW;
        end else if (dec_opcode == rvc_pkg::OPC_STORE && dec_f3 == rvc_pkg::F3_ZERO) begin
            dec_op = OP_SB;
        end else begin
            dec_known = 1'b0;
        end
    end

    // ---------------- execute terms ----------------
    assign imm_i    = {{20{inst_reg[31]}}, inst_reg[31:20]};
    assign imm_s    = {{20{inst_reg[31]}}, inst_reg[31:25], inst_reg[11:7]};
    assign sum_i    = rf_q1 + imm_i;
    assign sum_s    = rf_q1 + imm_s;
    assign pc_plus4 = pc_reg + 32'd4;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next     = state_reg;
        clear_row_next = clear_row_reg;
        pc_next        = pc_reg;
        halt_next      = halt_reg;
        inst_next      = inst_reg;
        op_next        = op_reg;

        done       = 1'b0;
        res_status = rvc_pkg::STAT_EXEC;
        res_inst   = inst_reg;

        // default memory access: read at the PC (instruction fetch)
        mem_req.be    = rvc_pkg::BE_NONE;
        mem_req.addr  = pc_reg[rvc_pkg::MEM_AW-1:0];
        mem_req.wdata = '0;

        rf_we    = 1'b0;
        rf_wdata = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_req.be     = rvc_pkg::BE_WORD;
                mem_req.addr   = {clear_row_reg, 2'b00};
                clear_row_next = clear_row_reg + {{(rvc_pkg::ROW_AW-1){1'b0}}, 1'b1};
                if (&clear_row_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    if (!ibuf_cmd_reg) begin
                        // memory word write, done in place
                        mem_req.be    = rvc_pkg::BE_WORD;
                        mem_req.addr  = ibuf_addr_reg[rvc_pkg::MEM_AW-1:0];
                        mem_req.wdata = ibuf_data_reg;
                        done          = 1'b1;
                        res_status    = rvc_pkg::STAT_WRITTEN;
                        res_inst      = '0;
                    end else begin
                        // fetch issued by the default read at the PC
                        state_next = ST_DECODE;
                    end
                end
            end
            ST_DECODE: begin
                inst_next = mem_rdata;
                op_next   = dec_op;
                res_inst  = mem_rdata;
                if (halt_reg != rvc_pkg::HALT_RUN) begin
                    done       = 1'b1;
                    res_status = {1'b0, halt_reg};
                    state_next = ST_IDLE;
                end else if (dec_known) begin
                    state_next = ST_EXEC;
                end else begin
                    if (mem_rdata == rvc_pkg::INST_EBREAK) begin
                        halt_next = (rf_a0 == '0) ? rvc_pkg::HALT_GOOD : rvc_pkg::HALT_BAD;
                    end else begin
                        halt_next = rvc_pkg::HALT_UNKNOWN;
                    end
                    done       = 1'b1;
                    res_status = {1'b0, halt_next};
                    state_next = ST_IDLE;
                end
            end
            ST_EXEC: begin
                done       = 1'b1;
                state_next = ST_IDLE;
                pc_next    = pc_plus4;
                unique case (op_reg)
                    OP_ADDI: begin
                        rf_we    = 1'b1;
                        rf_wdata = sum_i;
                    end
                    OP_JALR: begin
                        // target from the old rs1 value, then link
                        rf_we    = 1'b1;
                        rf_wdata = pc_plus4;
                        pc_next  = {sum_i[31:1], 1'b0};
                    end
                    OP_ADD: begin
                        rf_we    = 1'b1;
                        rf_wdata = rf_q1 + rf_q2;
                    end
                    OP_LUI: begin
                        rf_we    = 1'b1;
                        rf_wdata = {inst_reg[31:12], 12'd0};
                    end
                    OP_LW, OP_LBU: begin
                        mem_req.addr = sum_i[rvc_pkg::MEM_AW-1:0];
                        done         = 1'b0;
                        pc_next      = pc_reg;
                        state_next   = ST_LOAD;
                    end
                    OP_SW: begin
                        mem_req.be    = rvc_pkg::BE_WORD;
                        mem_req.addr  = sum_s[rvc_pkg::MEM_AW-1:0];
                        mem_req.wdata = rf_q2;
                    end
                    OP_SB: begin
                        mem_req.be    = rvc_pkg::BE_BYTE;
                        mem_req.addr  = sum_s[rvc_pkg::MEM_AW-1:0];
                        mem_req.wdata = rf_q2;
                    end
                endcase
            end
            ST_LOAD: begin
                rf_we      = 1'b1;
                rf_wdata   = (op_reg == OP_LW) ? mem_rdata : {24'd0, mem_rdata[7:0]};
                pc_next    = pc_plus4;
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid_next = done || (m_tvalid_reg && !m_tready);

    // ---------------- storage ----------------
    rvc_mem u_mem (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    rvc_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rs1     (mem_rdata[19:15]),
        .rs2     (mem_rdata[24:20]),
        .q1      (rf_q1),
        .q2      (rf_q2),
        .we      (rf_we),
        .waddr   (inst_reg[11:7]),
        .wdata   (rf_wdata),
        .a0_next (rf_a0)
    );

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clear_row_reg  <= '0;
            pc_reg         <= '0;
            halt_reg       <= rvc_pkg::HALT_RUN;
            ibuf_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clear_row_reg  <= clear_row_next;
            pc_reg         <= pc_next;
            halt_reg       <= halt_next;
            ibuf_valid_reg <= ibuf_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        inst_reg <= inst_next;
        op_reg   <= op_next;
        if (s_take) begin
            ibuf_cmd_reg  <= s_tuser[0];
            ibuf_addr_reg <= s_tdata[19:0];
            ibuf_data_reg <= s_tdata[51:20];
        end
        if (done) begin
            out_status_reg <= res_status;
            out_pc_reg     <= pc_next;
            out_inst_reg   <= res_inst;
            out_a0_reg     <= rf_a0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_a0_reg, out_inst_reg, out_pc_reg};

`ifndef ASSERT_OFF
    // a result from any state past idle goes only into an empty output register
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (done && state_reg != ST_IDLE) |-> !m_tvalid_reg)
        else $error("result overwrote a pending output");

    // a halted core keeps its halt kind and its PC
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (halt_reg != rvc_pkg::HALT_RUN) |=> (halt_reg == $past(halt_reg)))
        else $error("halt code changed after halting");

    a_halt_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        (halt_reg != rvc_pkg::HALT_RUN) |=> $stable(pc_reg))
        else $error("PC moved while halted");

    // no item enters while the memory is still being cleared
    a_clear_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (!s_tready && !ibuf_valid_reg && !m_tvalid_reg))
        else $error("item activity during memory clear");
`endif

endmodule
